@@ rtl/bpfs_pkg.sv @@
// ----------------------------------------------------------------------------
// bpfs_pkg
// Shared constants, codes and command type for the frame sampler.
// ----------------------------------------------------------------------------
package bpfs_pkg;

    localparam int MAX_QUBITS = 64;
    localparam int MAX_WORDS  = 16;
    localparam int WORD_BITS  = 64;
    localparam int QW         = $clog2(MAX_QUBITS);
    localparam int WW         = $clog2(MAX_WORDS);
    localparam int AW         = QW + WW;
    localparam int DEPTH      = MAX_QUBITS * MAX_WORDS;
    localparam int SHOT_W     = 11;
    localparam int NQ_W       = 7;
    localparam logic [SHOT_W-1:0] MAX_SHOTS = SHOT_W'(MAX_WORDS * WORD_BITS);

    localparam logic [3:0] F_H      = 4'd0;
    localparam logic [3:0] F_S      = 4'd1;
    localparam logic [3:0] F_CNOT   = 4'd2;
    localparam logic [3:0] F_CZ     = 4'd3;
    localparam logic [3:0] F_SWAP   = 4'd4;
    localparam logic [3:0] F_DEPOL  = 4'd5;
    localparam logic [3:0] F_FLIP   = 4'd6;
    localparam logic [3:0] F_MEAS   = 4'd7;
    localparam logic [3:0] F_NMEAS  = 4'd8;
    localparam logic [3:0] F_RESET  = 4'd9;
    localparam logic [3:0] F_CLEAR  = 4'd10;

    localparam logic [1:0] REG_NUM_QUBITS = 2'd0;
    localparam logic [1:0] REG_NUM_SHOTS  = 2'd1;
    localparam logic [1:0] REG_RNG_SEED   = 2'd2;

    localparam logic [32:0] P_ONE = 33'h1_0000_0000;

    localparam logic [63:0] GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX2  = 64'h94D049BB133111EB;

    typedef struct packed {
        logic [3:0]    func;
        logic [QW-1:0] qa;
        logic [QW-1:0] qb;
        logic [32:0]   prob;
    } cmd_t;

endpackage

@@ rtl/bpfs_if.sv @@
// ----------------------------------------------------------------------------
// bpfs_in_if / bpfs_out_if
// Valid/ready channels for requests and measurement results.
// ----------------------------------------------------------------------------
interface bpfs_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  func;
    logic [5:0]  qubit_a;
    logic [5:0]  qubit_b;
    logic [32:0] probability;

    modport source (output valid, func, qubit_a, qubit_b, probability, input ready);
    modport sink (input valid, func, qubit_a, qubit_b, probability, output ready);
endinterface

interface bpfs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] shot_bits;
    logic [3:0]  word_index;
    logic        last;

    modport source (output valid, shot_bits, word_index, last, input ready);
    modport sink (input valid, shot_bits, word_index, last, output ready);
endinterface

@@ rtl/bpfs_ram.sv @@
// ----------------------------------------------------------------------------
// bpfs_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bpfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

@@ rtl/bpfs_front.sv @@
// ----------------------------------------------------------------------------
// bpfs_front
// Accepts requests, drops no-ops, queues commands for the word engine.
// ----------------------------------------------------------------------------
module bpfs_front (
    input  logic                        clk,
    input  logic                        rst_n,
    bpfs_in_if.sink                     in_ch,
    input  logic [bpfs_pkg::NQ_W-1:0]   qubit_count,
    output bpfs_pkg::cmd_t              head,
    output logic                        head_valid,
    input  logic                        pop
);

    bpfs_pkg::cmd_t fifo_reg [2];
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    logic           accept, ok_a, ok_b, two_q, noop;
    logic           push;
    bpfs_pkg::cmd_t in_cmd;
    logic [32:0]    p_sat;

    assign in_ch.ready = (count_reg != 2'd2);
    assign accept      = in_ch.valid && in_ch.ready;
    assign head        = fifo_reg[rd_ptr_reg];
    assign head_valid  = (count_reg != 2'd0);

    always_comb
    begin
        p_sat = (in_ch.probability > bpfs_pkg::P_ONE) ? bpfs_pkg::P_ONE : in_ch.probability;
        ok_a  = {1'b0, in_ch.qubit_a} < qubit_count;
        ok_b  = {1'b0, in_ch.qubit_b} < qubit_count;
        two_q = (in_ch.func == bpfs_pkg::F_CNOT) || (in_ch.func == bpfs_pkg::F_CZ)
             || (in_ch.func == bpfs_pkg::F_SWAP);
        noop  = (in_ch.func > bpfs_pkg::F_CLEAR)
             || ((in_ch.func != bpfs_pkg::F_CLEAR) && !ok_a)
             || (two_q && (!ok_b || (in_ch.qubit_a == in_ch.qubit_b)));
        in_cmd.func = in_ch.func;
        in_cmd.qa   = in_ch.qubit_a;
        in_cmd.qb   = in_ch.qubit_b;
        in_cmd.prob = p_sat;
        push        = accept && !noop;
    end

    always_comb
    begin
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[rd_ptr_reg ^ count_reg[0]] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/bpfs_rng.sv @@
// ----------------------------------------------------------------------------
// bpfs_rng
// Pipelined splitmix64 generator, one draw per issue, results in order.
// ----------------------------------------------------------------------------
module bpfs_rng (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_load,
    input  logic [63:0] seed,
    input  logic        issue,
    output logic        rand_valid,
    output logic [63:0] rand_val,
    output logic [63:0] state
);

    logic [63:0] state_reg, state_next;
    logic [4:0]  vld_reg;
    logic [63:0] a0_reg, b_reg, out_reg;
    logic [63:0] ll1_reg, ll2_reg;
    logic [31:0] x1_reg, x2_reg;
    logic [63:0] z, m1, m2;
    logic [31:0] lh1, hl1, lh2, hl2;

    assign state      = state_reg;
    assign rand_valid = vld_reg[4];
    assign rand_val   = out_reg;

    always_comb
    begin
        state_next = state_reg;
        if (seed_load)
        begin
            state_next = seed;
        end
        else if (issue)
        begin
            state_next = state_reg + bpfs_pkg::GAMMA;
        end
        z   = state_reg + bpfs_pkg::GAMMA;
        lh1 = a0_reg[31:0] * bpfs_pkg::MIX1[63:32];
        hl1 = a0_reg[63:32] * bpfs_pkg::MIX1[31:0];
        m1  = ll1_reg + {x1_reg, 32'b0};
        lh2 = b_reg[31:0] * bpfs_pkg::MIX2[63:32];
        hl2 = b_reg[63:32] * bpfs_pkg::MIX2[31:0];
        m2  = ll2_reg + {x2_reg, 32'b0};
    end

    always_ff @(posedge clk)
    begin
        a0_reg  <= z ^ (z >> 30);
        ll1_reg <= 64'(a0_reg[31:0]) * 64'(bpfs_pkg::MIX1[31:0]);
        x1_reg  <= lh1 + hl1;
        b_reg   <= m1 ^ (m1 >> 27);
        ll2_reg <= 64'(b_reg[31:0]) * 64'(bpfs_pkg::MIX2[31:0]);
        x2_reg  <= lh2 + hl2;
        out_reg <= m2 ^ (m2 >> 31);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            vld_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= {vld_reg[3:0], issue};
        end
    end

endmodule

@@ rtl/bpfs_back.sv @@
// ----------------------------------------------------------------------------
// bpfs_back
// Walks the row words of a queued command, applies it, emits measurements.
// ----------------------------------------------------------------------------
module bpfs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpfs_pkg::cmd_t                head,
    input  logic                          head_valid,
    output logic                          pop,
    input  logic [bpfs_pkg::SHOT_W-1:0]   shot_count,
    input  logic                          seed_load,
    input  logic [63:0]                   seed,
    output logic [63:0]                   gen_state,
    bpfs_out_if.source                    out_ch
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_DRAW = 3'd2;
    localparam logic [2:0] ST_CALC = 3'd3;
    localparam logic [2:0] ST_WRB  = 3'd4;

    logic [2:0]                      state_reg, state_next;
    logic [bpfs_pkg::WW-1:0]         w_reg, w_next;
    logic [6:0]                      iss_reg, iss_next, col_reg, col_next;
    logic [63:0]                     mx_reg, mx_next, mz_reg, mz_next;
    logic [bpfs_pkg::MAX_QUBITS-1:0] rowv_reg, rowv_next;
    logic [63:0]                     bx_reg, bx_next, bz_reg, bz_next;
    logic                            ov_reg, ov_next;
    logic [63:0]                     obits_reg, obits_next;
    logic [3:0]                      oidx_reg, oidx_next;
    logic                            olast_reg, olast_next;

    logic [bpfs_pkg::SHOT_W-1:0] shots, rem_shots;
    logic [4:0]                  words;
    logic [6:0]                  nb;
    logic [63:0]                 vmask;
    logic                        in_range, two_q, noisy, measuring;
    logic [bpfs_pkg::AW-1:0]     addr_a, addr_b;
    logic                        re, we;
    logic [bpfs_pkg::AW-1:0]     waddr;
    logic [63:0]                 wx, wz;
    logic [63:0]                 xa_d, za_d, xb_d, zb_d;
    logic [63:0]                 xa, za, xb, zb;
    logic [63:0]                 nax, naz, nbx, nbz;
    logic                        issue, rvalid, fx, fz;
    logic [63:0]                 u;
    logic [65:0]                 u3;

    bpfs_rng u_rng (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_load  (seed_load),
        .seed       (seed),
        .issue      (issue),
        .rand_valid (rvalid),
        .rand_val   (u),
        .state      (gen_state)
    );

    bpfs_ram #(.WIDTH(64), .DEPTH(bpfs_pkg::DEPTH)) u_xram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wx),
        .re     (re),
        .raddr0 (addr_a),
        .raddr1 (addr_b),
        .rdata0 (xa_d),
        .rdata1 (xb_d)
    );

    bpfs_ram #(.WIDTH(64), .DEPTH(bpfs_pkg::DEPTH)) u_zram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wz),
        .re     (re),
        .raddr0 (addr_a),
        .raddr1 (addr_b),
        .rdata0 (za_d),
        .rdata1 (zb_d)
    );

    assign out_ch.valid      = ov_reg;
    assign out_ch.shot_bits  = obits_reg;
    assign out_ch.word_index = oidx_reg;
    assign out_ch.last       = olast_reg;

    always_comb
    begin
        shots     = (shot_count > bpfs_pkg::MAX_SHOTS) ? bpfs_pkg::MAX_SHOTS : shot_count;
        words     = 5'((12'(shots) + 12'd63) >> 6);
        rem_shots = shots - {1'b0, w_reg, 6'b0};
        nb        = (rem_shots >= 11'd64) ? 7'd64 : rem_shots[6:0];
        vmask     = (nb == 7'd64) ? '1 : ((64'd1 << nb[5:0]) - 64'd1);
        in_range  = {1'b0, w_reg} < words;
        addr_a    = {head.qa, w_reg};
        addr_b    = {head.qb, w_reg};
        two_q     = (head.func == bpfs_pkg::F_CNOT) || (head.func == bpfs_pkg::F_CZ)
                 || (head.func == bpfs_pkg::F_SWAP);
        noisy     = ((head.func == bpfs_pkg::F_DEPOL) || (head.func == bpfs_pkg::F_FLIP)
                 || (head.func == bpfs_pkg::F_NMEAS)) && (head.prob != 33'd0) && in_range;
        measuring = ((head.func == bpfs_pkg::F_MEAS) || (head.func == bpfs_pkg::F_NMEAS))
                 && in_range;
        xa = rowv_reg[head.qa] ? xa_d : '0;
        za = rowv_reg[head.qa] ? za_d : '0;
        xb = rowv_reg[head.qb] ? xb_d : '0;
        zb = rowv_reg[head.qb] ? zb_d : '0;
    end

    always_comb
    begin
        nax = xa;
        naz = za;
        nbx = xb;
        nbz = zb;
        if (in_range)
        begin
            case (head.func)
                bpfs_pkg::F_H:
                begin
                    nax = za;
                    naz = xa;
                end
                bpfs_pkg::F_S:     naz = za ^ xa;
                bpfs_pkg::F_CNOT:
                begin
                    nbx = xb ^ xa;
                    naz = za ^ zb;
                end
                bpfs_pkg::F_CZ:
                begin
                    nbz = zb ^ xa;
                    naz = za ^ xb;
                end
                bpfs_pkg::F_SWAP:
                begin
                    nax = xb;
                    naz = zb;
                    nbx = xa;
                    nbz = za;
                end
                bpfs_pkg::F_DEPOL:
                begin
                    nax = xa ^ mx_reg;
                    naz = za ^ mz_reg;
                end
                bpfs_pkg::F_FLIP:  nax = xa ^ mx_reg;
                bpfs_pkg::F_NMEAS, bpfs_pkg::F_RESET:
                begin
                    nax = '0;
                    naz = '0;
                end
                default:
                begin
                    nax = xa;
                end
            endcase
        end
    end

    // u below floor(k*p*2^64/3) exactly when 3u+2 is below k*p*2^64
    always_comb
    begin
        fx = 1'b0;
        fz = 1'b0;
        u3 = {2'b00, u} + {1'b0, u, 1'b0} + 66'd2;
        if (head.func == bpfs_pkg::F_DEPOL)
        begin
            if (u3 < {1'b0, head.prob, 32'b0})
            begin
                fx = 1'b1;
            end
            else if (u3 < {head.prob, 33'b0})
            begin
                fx = 1'b1;
                fz = 1'b1;
            end
            else if ({1'b0, u[63:32]} < head.prob)
            begin
                fz = 1'b1;
            end
        end
        else
        begin
            fx = {1'b0, u[63:32]} < head.prob;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        w_next     = w_reg;
        iss_next   = iss_reg;
        col_next   = col_reg;
        mx_next    = mx_reg;
        mz_next    = mz_reg;
        rowv_next  = rowv_reg;
        bx_next    = bx_reg;
        bz_next    = bz_reg;
        ov_next    = ov_reg && !out_ch.ready;
        obits_next = obits_reg;
        oidx_next  = oidx_reg;
        olast_next = olast_reg;
        pop        = 1'b0;
        re         = 1'b0;
        we         = 1'b0;
        waddr      = addr_a;
        wx         = nax;
        wz         = naz;
        issue      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.func == bpfs_pkg::F_CLEAR)
                    begin
                        rowv_next = '0;
                        pop       = 1'b1;
                    end
                    else
                    begin
                        w_next     = '0;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                re         = 1'b1;
                iss_next   = '0;
                col_next   = '0;
                mx_next    = '0;
                mz_next    = '0;
                state_next = noisy ? ST_DRAW : ST_CALC;
            end
            ST_DRAW:
            begin
                issue = iss_reg < nb;
                if (issue)
                begin
                    iss_next = iss_reg + 7'd1;
                end
                if (rvalid)
                begin
                    mx_next  = mx_reg | (64'(fx) << col_reg[5:0]);
                    mz_next  = mz_reg | (64'(fz) << col_reg[5:0]);
                    col_next = col_reg + 7'd1;
                end
                if (col_reg == nb)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (!measuring || !ov_reg || out_ch.ready)
                begin
                    we = 1'b1;
                    if (measuring)
                    begin
                        ov_next    = 1'b1;
                        obits_next = (xa ^ mx_reg) & vmask;
                        oidx_next  = 4'(w_reg);
                        olast_next = ({1'b0, w_reg} + 5'd1) == words;
                    end
                    bx_next = nbx;
                    bz_next = nbz;
                    if (two_q)
                    begin
                        state_next = ST_WRB;
                    end
                    else
                    begin
                        state_next = ST_RD;
                        w_next     = w_reg + bpfs_pkg::WW'(1);
                        if (w_reg == bpfs_pkg::WW'(bpfs_pkg::MAX_WORDS - 1))
                        begin
                            rowv_next[head.qa] = 1'b1;
                            pop                = 1'b1;
                            state_next         = ST_IDLE;
                        end
                    end
                end
            end
            ST_WRB:
            begin
                we         = 1'b1;
                waddr      = addr_b;
                wx         = bx_reg;
                wz         = bz_reg;
                state_next = ST_RD;
                w_next     = w_reg + bpfs_pkg::WW'(1);
                if (w_reg == bpfs_pkg::WW'(bpfs_pkg::MAX_WORDS - 1))
                begin
                    rowv_next[head.qa] = 1'b1;
                    rowv_next[head.qb] = 1'b1;
                    pop                = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mx_reg    <= mx_next;
        mz_reg    <= mz_next;
        bx_reg    <= bx_next;
        bz_reg    <= bz_next;
        obits_reg <= obits_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            w_reg     <= '0;
            iss_reg   <= '0;
            col_reg   <= '0;
            rowv_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            w_reg     <= w_next;
            iss_reg   <= iss_next;
            col_reg   <= col_next;
            rowv_reg  <= rowv_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

@@ rtl/batched_pauli_frame_sampler_top.sv @@
// ----------------------------------------------------------------------------
// batched_pauli_frame_sampler_top
// Bit-packed Pauli frame sampler: request queue, word engine, config port.
// ----------------------------------------------------------------------------
// Requests are classified and held in a two-entry queue by the front end; the
// word engine walks all 16 words of the addressed rows through
// single-port-write row memories, with a read state and a compute state per
// word for one-qubit operations and an added write-back state for the second
// row of two-qubit gates, after dispatch from the idle state. A noisy word
// adds one generator draw per valid shot and waits for the pipelined generator
// results, and a measurement word waits while the previous result is still
// held at the output. Clear is done in the idle state. Rows read as zero
// until first written after reset or clear, so no clearing pass is run.
module batched_pauli_frame_sampler_top (
    input  logic        clk,
    input  logic        rst_n,
    bpfs_in_if.sink     in_ch,
    bpfs_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [bpfs_pkg::NQ_W-1:0]   nq_reg, nq_next;
    logic [bpfs_pkg::SHOT_W-1:0] ns_reg, ns_next;
    logic                        wr, seed_load;
    logic [63:0]                 gen_state;
    bpfs_pkg::cmd_t              head;
    logic                        head_valid, pop;

    assign pready    = 1'b1;
    assign wr        = psel && penable && pwrite;
    assign seed_load = wr && (paddr[4:3] == bpfs_pkg::REG_RNG_SEED);

    always_comb
    begin
        nq_next = nq_reg;
        ns_next = ns_reg;
        if (wr && (paddr[4:3] == bpfs_pkg::REG_NUM_QUBITS))
        begin
            nq_next = pwdata[bpfs_pkg::NQ_W-1:0];
        end
        if (wr && (paddr[4:3] == bpfs_pkg::REG_NUM_SHOTS))
        begin
            ns_next = pwdata[bpfs_pkg::SHOT_W-1:0];
        end
        case (paddr[4:3])
            bpfs_pkg::REG_NUM_QUBITS: prdata = 64'(nq_reg);
            bpfs_pkg::REG_NUM_SHOTS:  prdata = 64'(ns_reg);
            bpfs_pkg::REG_RNG_SEED:   prdata = gen_state;
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nq_reg <= bpfs_pkg::NQ_W'(bpfs_pkg::MAX_QUBITS);
            ns_reg <= bpfs_pkg::MAX_SHOTS;
        end
        else
        begin
            nq_reg <= nq_next;
            ns_reg <= ns_next;
        end
    end

    bpfs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .qubit_count (nq_reg),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop)
    );

    bpfs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .shot_count (ns_reg),
        .seed_load  (seed_load),
        .seed       (pwdata),
        .gen_state  (gen_state),
        .out_ch     (out_ch)
    );

endmodule
